>>> sv/mpeg_pes_header_parser_assert.svh
// assertion macros shared by the rtl
`ifndef MPEG_PES_HEADER_PARSER_ASSERT_SVH
`define MPEG_PES_HEADER_PARSER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MPHP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define MPHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/mphp_pkg.sv
`default_nettype none
package mphp_pkg;

   localparam int TS_W        = 33;
   localparam int POS_W       = 9;
   localparam int RSP_TDATA_W = 104;

   // byte positions inside the pes header
   localparam logic [POS_W-1:0] POS_STREAM_ID = 9'd3;
   localparam logic [POS_W-1:0] POS_LEN_HI    = 9'd4;
   localparam logic [POS_W-1:0] POS_LEN_LO    = 9'd5;
   localparam logic [POS_W-1:0] POS_FLAGS     = 9'd7;
   localparam logic [POS_W-1:0] POS_HDR_LEN   = 9'd8;
   localparam logic [POS_W-1:0] POS_PTS_FIRST = 9'd9;
   localparam logic [POS_W-1:0] POS_DTS_FIRST = 9'd14;
   localparam logic [POS_W-1:0] POS_DTS_END   = 9'd19;
   localparam logic [POS_W-1:0] HDR_FIXED_LEN = 9'd9;

   // result status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_SHORT = 1'b1;

   // result tdata layout
   localparam int SID_LSB   = 0;
   localparam int LEN_LSB   = 8;
   localparam int HPTS_BIT  = 24;
   localparam int HDTS_BIT  = 25;
   localparam int PTS_LSB   = 26;
   localparam int DTS_LSB   = 59;
   localparam int TOTAL_LSB = 92;

   typedef enum logic [2:0] {
      CAP_NONE,
      CAP_SID,
      CAP_LEN_HI,
      CAP_LEN_LO,
      CAP_FLAGS,
      CAP_PTS,
      CAP_DTS
   } cap_type;

   typedef enum logic [1:0] {
      FIN_NONE,
      FIN_OK,
      FIN_SHORT
   } fin_type;

   // one classified byte handed from front to back
   typedef struct packed {
      logic       start;
      cap_type    cap;
      logic [2:0] part;
      fin_type    fin;
      logic [7:0] data;
      logic [7:0] hdl;
   } op_type;

   // placement of one timestamp byte, marker bits dropped
   function automatic logic [TS_W-1:0] ts_part(input logic [2:0] part,
                                                input logic [7:0] b);
      logic [TS_W-1:0] ts;
      ts = '0;
      case (part)
         3'd0:    ts[32:30] = b[3:1];
         3'd1:    ts[29:22] = b;
         3'd2:    ts[21:15] = b[7:1];
         3'd3:    ts[14:7]  = b;
         3'd4:    ts[6:0]   = b[7:1];
         default: ts = '0;
      endcase
      return ts;
   endfunction

endpackage
`default_nettype wire

>>> sv/mpeg_pes_header_parser.sv
// PES header parser. Header bytes enter one per transfer on the req_ channel:
// tdata carries the byte, tuser marks byte 0 of a new header (restarting any
// parse in progress) and tlast marks the final byte of the available data.
// One result leaves on the rsp_ channel per header not cut off by a restart;
// tuser is the status (0 complete, 1 data ended early with all tdata zero),
// tdata carries stream id, packet length, PTS/DTS flags, the 33-bit
// timestamps and the total header length. Bytes outside a parse are dropped
// without a result. Throughput is one byte per cycle while the queue is not
// full: the front end classifies a byte in the cycle it is taken, the back
// end applies one queued byte per cycle unless a result waits for the output
// register. With an empty queue, the completing byte is written into the
// queue as it transfers and the back end then moves it into the result
// register that drives rsp_tvalid. A stalled receiver leaves the result held
// there, the back end keeps draining capture-only bytes and stops at the next
// result; req_tready drops only once the QUEUE_DEPTH-entry queue is full.
// Reset empties the queue, drops any result and leaves the parser idle.
`default_nettype none
module mpeg_pes_header_parser
   import mphp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire  [7:0]             req_tdata,   // [7:0] data_byte
   input  wire                    req_tuser,   // first_byte
   input  wire                    req_tlast,   // last_byte
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   // [7:0] stream_id, [23:8] packet_length, [24] has_pts, [25] has_dts,
   // [58:26] pts_value, [91:59] dts_value, [100:92] total_header_length
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser    // status
);

`include "mpeg_pes_header_parser_assert.svh"

   op_type push_op, pop_op;
   logic   push, pop, full, empty;

   // byte classification
   mphp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_op    (push_op),
      .full       (full)
   );

   // decoupling queue
   mphp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (full),
      .pop     (pop),
      .pop_op  (pop_op),
      .empty   (empty)
   );

   // capture and result build
   mphp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_op     (pop_op),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // checks
   `MPHP_ASSERT_IMP(a_short_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "incomplete result carries data")
   `MPHP_ASSERT_IMP(a_ok_len, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[TOTAL_LSB +: POS_W] >= HDR_FIXED_LEN, "header length below fixed part")
   `MPHP_ASSERT_IMP(a_pts_absent, clock, reset, rsp_tvalid && !rsp_tuser && !rsp_tdata[HPTS_BIT], rsp_tdata[PTS_LSB +: TS_W] == '0, "pts set without flag")
   `MPHP_ASSERT_NEXT(a_no_stall_pop, clock, reset, full && !pop, !req_tready, "queue took data while full")

endmodule
`default_nettype wire

>>> sv/mphp_fifo.sv
`default_nettype none
module mphp_fifo
   import mphp_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire    clock,
   input  wire    reset,
   input  wire    push,
   input  op_type push_op,
   output logic   full,
   input  wire    pop,
   output op_type pop_op,
   output logic   empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   op_type          mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_op  = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

>>> sv/mphp_front.sv
`default_nettype none
module mphp_front
   import mphp_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] data_byte
   input  wire        req_tuser,   // first_byte
   input  wire        req_tlast,   // last_byte
   output logic       push,
   output op_type     push_op,
   input  wire        full
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             active_ff, active_in;
   logic [7:0]       hdl_ff, hdl_in;

   logic             xfer, act, done;
   logic [POS_W-1:0] p, p_rel;
   logic [7:0]       hdl_eff;
   cap_type          cap;
   fin_type          fin;

   assign req_tready = !full;
   assign xfer       = req_tvalid && req_tready;

   // classify the byte by its position
   always_comb begin
      act     = req_tuser || active_ff;
      p       = req_tuser ? '0 : pos_ff;
      hdl_eff = (p == POS_HDR_LEN) ? req_tdata : (req_tuser ? 8'd0 : hdl_ff);
      p_rel   = '0;
      cap     = CAP_NONE;
      if (p == POS_STREAM_ID) begin
         cap = CAP_SID;
      end else if (p == POS_LEN_HI) begin
         cap = CAP_LEN_HI;
      end else if (p == POS_LEN_LO) begin
         cap = CAP_LEN_LO;
      end else if (p == POS_FLAGS) begin
         cap = CAP_FLAGS;
      end else if (p >= POS_PTS_FIRST && p < POS_DTS_FIRST) begin
         cap   = CAP_PTS;
         p_rel = p - POS_PTS_FIRST;
      end else if (p >= POS_DTS_FIRST && p < POS_DTS_END) begin
         cap   = CAP_DTS;
         p_rel = p - POS_DTS_FIRST;
      end
      done = (p >= POS_HDR_LEN) && (p == POS_HDR_LEN + {1'b0, hdl_eff});
      if (done) begin
         fin = FIN_OK;
      end else if (req_tlast) begin
         fin = FIN_SHORT;
      end else begin
         fin = FIN_NONE;
      end
   end

   // only bytes that change the back end are queued
   assign push          = xfer && act && (req_tuser || cap != CAP_NONE || fin != FIN_NONE);
   assign push_op.start = req_tuser;
   assign push_op.cap   = cap;
   assign push_op.part  = p_rel[2:0];
   assign push_op.fin   = fin;
   assign push_op.data  = req_tdata;
   assign push_op.hdl   = hdl_eff;

   // parse position tracking
   always_comb begin
      pos_in    = pos_ff;
      active_in = active_ff;
      hdl_in    = hdl_ff;
      if (xfer && act) begin
         hdl_in    = hdl_eff;
         active_in = (fin == FIN_NONE);
         pos_in    = p + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         active_ff <= active_in;
      end
      hdl_ff <= hdl_in;
   end

endmodule
`default_nettype wire

>>> sv/mphp_back.sv
`default_nettype none
module mphp_back
   import mphp_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  op_type                 pop_op,
   input  wire                    empty,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   // [7:0] stream_id, [23:8] packet_length, [24] has_pts, [25] has_dts,
   // [58:26] pts_value, [91:59] dts_value, [100:92] total_header_length
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser    // status
);

   logic [7:0]            sid_ff, sid_in;
   logic [15:0]           len_ff, len_in;
   logic [1:0]            flags_ff, flags_in;
   logic [TS_W-1:0]       pts_ff, pts_in;
   logic [TS_W-1:0]       dts_ff, dts_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign pop       = !empty && (pop_op.fin == FIN_NONE || slot_free);

   // apply the captured byte
   always_comb begin
      if (pop_op.start) begin
         sid_in   = '0;
         len_in   = '0;
         flags_in = '0;
         pts_in   = '0;
         dts_in   = '0;
      end else begin
         sid_in   = sid_ff;
         len_in   = len_ff;
         flags_in = flags_ff;
         pts_in   = pts_ff;
         dts_in   = dts_ff;
      end
      case (pop_op.cap)
         CAP_SID:    sid_in       = pop_op.data;
         CAP_LEN_HI: len_in[15:8] = pop_op.data;
         CAP_LEN_LO: len_in[7:0]  = pop_op.data;
         CAP_FLAGS:  flags_in     = pop_op.data[7:6];
         CAP_PTS:    pts_in       = pts_in | ts_part(pop_op.part, pop_op.data);
         CAP_DTS:    dts_in       = dts_in | ts_part(pop_op.part, pop_op.data);
         default:    sid_in       = sid_in;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      if (pop && pop_op.fin != FIN_NONE) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (pop_op.fin == FIN_OK) begin
            rsp_status_in                    = STATUS_OK;
            rsp_data_in[SID_LSB +: 8]        = sid_in;
            rsp_data_in[LEN_LSB +: 16]       = len_in;
            rsp_data_in[HPTS_BIT]            = flags_in[1];
            rsp_data_in[HDTS_BIT]            = flags_in[0];
            rsp_data_in[PTS_LSB +: TS_W]     = flags_in[1] ? pts_in : '0;
            rsp_data_in[DTS_LSB +: TS_W]     = flags_in[0] ? dts_in : '0;
            rsp_data_in[TOTAL_LSB +: POS_W]  = HDR_FIXED_LEN + {1'b0, pop_op.hdl};
         end else begin
            rsp_status_in = STATUS_SHORT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      if (pop) begin
         sid_ff   <= sid_in;
         len_ff   <= len_in;
         flags_ff <= flags_in;
         pts_ff   <= pts_in;
         dts_ff   <= dts_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
`default_nettype wire
